// ===== rtl/ccmd_pkg.sv =====
// ----------------------------------------------------------------------------
// ccmd_pkg: shared types for the cyclic code minimum distance check
// Controller states, multiply operand select, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ccmd_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RED_WAIT,
        S_POW_GO,
        S_POW_WAIT,
        S_SEARCH,
        S_DONE
    } state_t;

    typedef enum logic {
        MUL_REDUCE,
        MUL_POWER
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     q_wr;
        logic     pow_wr;
        logic     search_step;
    } cmd_t;

    typedef struct packed {
        logic small_n;
        logic mul_busy;
        logic mul_done;
        logic pow_full;
        logic fail;
        logic last;
    } sts_t;

endpackage

// ===== rtl/ccmd_modmul.sv =====
// ----------------------------------------------------------------------------
// ccmd_modmul: bit-serial modular multiplier
// Forms a * b mod n, multiplier bits taken MSB first, each bit in two phases:
// double and reduce, then conditionally add b and reduce. b must be below n.
// ----------------------------------------------------------------------------
module ccmd_modmul #(
    parameter int W = 17
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] a_in,
    input  logic [W-1:0] b_in,
    input  logic [W-1:0] n_in,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] result
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          phase_reg, phase_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [W:0] dbl_w, dbl_red_w, sum_w, sum_red_w, n_w;

    always_comb begin
        n_w       = {1'b0, n_in};
        dbl_w     = {acc_reg, 1'b0};
        dbl_red_w = (dbl_w >= n_w) ? dbl_w - n_w : dbl_w;
        sum_w     = {1'b0, acc_reg} + {1'b0, b_reg};
        sum_red_w = (sum_w >= n_w) ? sum_w - n_w : sum_w;
    end

    always_comb begin
        acc_next   = acc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            acc_next   = '0;
            a_next     = a_in;
            b_next     = b_in;
            cnt_next   = CW'(W);
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                acc_next   = dbl_red_w[W-1:0];
                phase_next = 1'b1;
            end else begin
                if (a_reg[W-1]) begin
                    acc_next = sum_red_w[W-1:0];
                end
                a_next     = {a_reg[W-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                phase_next = 1'b0;
                if (cnt_reg == CW'(1)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ===== rtl/ccmd_datapath.sv =====
// ----------------------------------------------------------------------------
// ccmd_datapath: operand registers, power table and residue lanes
// Holds n, d and q, builds the powers of q through the serial multiplier,
// and steps one residue lane per coordinate, one offset per cycle.
// ----------------------------------------------------------------------------
module ccmd_datapath #(
    parameter int W = 17,
    parameter int C = 5
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  ccmd_pkg::cmd_t cmd,
    output ccmd_pkg::sts_t sts,
    input  logic [W-1:0]   load_modulus,
    input  logic [W-1:0]   load_multiplier,
    input  logic [W-1:0]   load_threshold
);
    import ccmd_pkg::*;

    localparam int IW = (C > 1) ? $clog2(C) : 1;

    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  pow_reg [C];
    logic [W-1:0]  pow_next [C];
    logic [W-1:0]  res_reg [C];
    logic [W-1:0]  res_next [C];
    logic [W-1:0]  count_reg, count_next;
    logic [IW-1:0] ptr_reg, ptr_next;

    logic [W:0]    sum_w [C];
    logic [W:0]    sub_w [C];
    logic [W-1:0]  step_w [C];
    logic [W-1:0]  diff_w [C];
    logic [W-1:0]  dist_w [C];
    logic [W-1:0]  best_w;

    logic          mul_busy, mul_done;
    logic [W-1:0]  mul_b, mul_res;

    // Raw q is reduced first (q * 1 mod n), then the same register is the multiplier
    assign mul_b = (cmd.mul_sel == MUL_REDUCE) ? W'(1) : pow_reg[ptr_reg];

    ccmd_modmul #(.W(W)) u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a_in    (q_reg),
        .b_in    (mul_b),
        .n_in    (n_reg),
        .busy    (mul_busy),
        .done    (mul_done),
        .result  (mul_res)
    );

    // Residue lanes: advance by the power, wrap once; distance from the held residue
    always_comb begin
        best_w = '0;
        for (int i = 0; i < C; i++) begin
            sum_w[i]  = {1'b0, res_reg[i]} + {1'b0, pow_reg[i]};
            sub_w[i]  = sum_w[i] - {1'b0, n_reg};
            step_w[i] = (sum_w[i] >= {1'b0, n_reg}) ? sub_w[i][W-1:0] : sum_w[i][W-1:0];
            diff_w[i] = n_reg - res_reg[i];
            dist_w[i] = (res_reg[i] < diff_w[i]) ? res_reg[i] : diff_w[i];
            if (dist_w[i] > best_w) begin
                best_w = dist_w[i];
            end
        end
    end

    always_comb begin
        n_next     = n_reg;
        d_next     = d_reg;
        q_next     = q_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        for (int i = 0; i < C; i++) begin
            pow_next[i] = pow_reg[i];
            res_next[i] = res_reg[i];
        end
        if (cmd.load) begin
            n_next      = load_modulus;
            d_next      = load_threshold;
            q_next      = load_multiplier;
            count_next  = '0;
            ptr_next    = '0;
            pow_next[0] = W'(1);
            for (int i = 0; i < C; i++) begin
                res_next[i] = '0;
            end
        end
        if (cmd.q_wr) begin
            q_next = mul_res;
        end
        if (cmd.pow_wr) begin
            for (int i = 1; i < C; i++) begin
                if ({1'b0, ptr_reg} + 1'b1 == (IW + 1)'(i)) begin
                    pow_next[i] = mul_res;
                end
            end
            ptr_next = ptr_reg + 1'b1;
        end
        if (cmd.search_step) begin
            count_next = count_reg + 1'b1;
            for (int i = 0; i < C; i++) begin
                res_next[i] = step_w[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ptr_reg   <= '0;
        end else begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg <= n_next;
        d_reg <= d_next;
        q_reg <= q_next;
        for (int i = 0; i < C; i++) begin
            pow_reg[i] <= pow_next[i];
            res_reg[i] <= res_next[i];
        end
    end

    always_comb begin
        sts.small_n  = (n_reg[W-1:1] == '0);
        sts.mul_busy = mul_busy;
        sts.mul_done = mul_done;
        sts.pow_full = (ptr_reg == IW'(C - 1));
        // Offset zero is the start point, not a checked offset
        sts.fail     = (count_reg != '0) && (best_w < d_reg);
        sts.last     = (count_reg != '0) && (count_reg == {1'b0, n_reg[W-1:1]});
    end

endmodule

// ===== rtl/ccmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ccmd_ctrl: sequencing state machine and result register
// Takes a request, runs reduction, power build and offset search, and
// holds the verdict in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module ccmd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic           meets,
    output ccmd_pkg::cmd_t cmd,
    input  ccmd_pkg::sts_t sts
);
    import ccmd_pkg::*;

    state_t state_reg, state_next;
    logic   verdict_reg, verdict_next;
    logic   m_valid_reg, m_valid_next;
    logic   meets_reg;
    logic   out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            verdict_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            meets_reg <= verdict_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        verdict_next = verdict_reg;
        cmd          = '0;
        out_load     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                // No offsets to search for a modulus below two
                if (sts.small_n) begin
                    verdict_next = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_REDUCE;
                    state_next    = S_RED_WAIT;
                end
            end
            S_RED_WAIT: begin
                if (sts.mul_done) begin
                    cmd.q_wr   = 1'b1;
                    state_next = S_POW_GO;
                end
            end
            S_POW_GO: begin
                if (sts.pow_full) begin
                    state_next = S_SEARCH;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_POWER;
                    state_next    = S_POW_WAIT;
                end
            end
            S_POW_WAIT: begin
                if (sts.mul_done) begin
                    cmd.pow_wr = 1'b1;
                    state_next = S_POW_GO;
                end
            end
            S_SEARCH: begin
                if (sts.fail) begin
                    verdict_next = 1'b0;
                    state_next   = S_DONE;
                end else if (sts.last) begin
                    verdict_next = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.search_step = 1'b1;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign meets    = meets_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_CHECK)
        else $error("request accepted but controller did not start");

    a_mul_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |-> !sts.mul_busy)
        else $error("multiplier started while busy");

    a_step_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.search_step |-> !sts.fail && !sts.last)
        else $error("search advanced past a finishing offset");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == S_DONE)
        else $error("result presented outside the finishing state");
`endif

endmodule

// ===== rtl/cyclic_code_min_distance_check.sv =====
// ----------------------------------------------------------------------------
// cyclic_code_min_distance_check: top level
// Checks that every offset of a cyclic code reaches a minimum distance.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one request carries modulus n, multiplier q and the
//   distance threshold d. s_tready is high only while the block is idle.
//   Output stream m_*: one result per request, the meets flag in bit 0.
//   Sequence: setup, then the reduction of q and each of the COORDINATES-1
//   powers through the serial modular multiplier, then the offset search,
//   up to floor(n/2) offsets; n below two finishes after setup.
//   The search stops at the first offset that falls short.
//   The verdict sits in an output register; a new request is taken as soon
//   as it has been loaded there, so a stalled receiver only holds back the
//   following result, not the next request.
//   Reset (aresetn low, synchronous) returns the block to idle and drops
//   any pending result.
// ----------------------------------------------------------------------------
module cyclic_code_min_distance_check #(
    parameter int MODULUS_BITS = 17,
    parameter int COORDINATES  = 5
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // modulus, multiplier, min_distance (MODULUS_BITS each), zero pad
    input  logic [((3*MODULUS_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // meets, zero pad
    output logic [7:0]                               m_tdata
);
    import ccmd_pkg::*;

    localparam int W = MODULUS_BITS;

    cmd_t cmd;
    sts_t sts;
    logic meets;

    ccmd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .meets    (meets),
        .cmd      (cmd),
        .sts      (sts)
    );

    ccmd_datapath #(.W(W), .C(COORDINATES)) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .load_modulus    (s_tdata[W-1:0]),
        .load_multiplier (s_tdata[2*W-1:W]),
        .load_threshold  (s_tdata[3*W-1:2*W])
    );

    assign m_tdata = {7'b0, meets};

endmodule

// ===== sim/ccmd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccmd_checker: result checker for the cyclic code minimum distance check
// Watches both streams. For every request taken it works out the expected
// meets flag and queues it. Each result taken is compared with the oldest
// entry in that queue. Mismatches are counted and handed to the top level.
// ----------------------------------------------------------------------------
module ccmd_checker #(
    parameter int MODULUS_BITS = 17,
    parameter int COORDINATES  = 5,
    parameter int IN_W         = ((3*MODULUS_BITS+7)/8)*8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  logic [7:0]      m_tdata,
    output int              mismatches,
    output int              outstanding
);

    typedef logic [MODULUS_BITS-1:0] value_t;

    typedef struct {
        value_t n;
        value_t q;
        value_t d;
        bit     meets;
    } verdict_t;

    verdict_t expected_verdicts[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Walk every offset up to n/2 and stop at the first one that falls short.
    function automatic bit meets_threshold(input value_t n, input value_t q,
                                           input value_t d);
        bit [63:0] power [COORDINATES];
        bit [63:0] residue [COORDINATES];
        bit [63:0] modulus;
        bit [63:0] gen;
        bit [63:0] best;
        bit [63:0] r;
        bit [63:0] cyc_dist;
        bit [63:0] offset;
        int        k;
        modulus = 64'(n);
        if (modulus == 0) begin
            return 1'b1;
        end
        gen      = 64'(q) % modulus;
        power[0] = 64'd1 % modulus;
        for (k = 1; k < COORDINATES; k++) begin
            power[k] = (power[k-1] * gen) % modulus;
        end
        for (k = 0; k < COORDINATES; k++) begin
            residue[k] = 64'd0;
        end
        for (offset = 1; offset <= (modulus >> 1); offset++) begin
            best = 64'd0;
            for (k = 0; k < COORDINATES; k++) begin
                r = residue[k] + power[k];
                if (r >= modulus) begin
                    r = r - modulus;
                end
                residue[k] = r;
                cyc_dist = modulus - r;
                if (r < cyc_dist) begin
                    cyc_dist = r;
                end
                if (cyc_dist > best) begin
                    best = cyc_dist;
                end
            end
            if (best < 64'(d)) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn) begin
            // Retire the result first: it can never belong to a request taken
            // at the same edge.
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: result meets=%0b with no request outstanding",
                                 $realtime, m_tdata[0]);
                    end
                    mismatches++;
                end else begin
                    v = expected_verdicts.pop_front();
                    if (m_tdata[0] !== v.meets) begin
                        if (mismatches < 10) begin
                            $display("%0t: n=%0d q=%0d d=%0d meets expected %0b got %0b",
                                     $realtime, v.n, v.q, v.d, v.meets, m_tdata[0]);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                v.n     = s_tdata[MODULUS_BITS-1:0];
                v.q     = s_tdata[2*MODULUS_BITS-1:MODULUS_BITS];
                v.d     = s_tdata[3*MODULUS_BITS-1:2*MODULUS_BITS];
                v.meets = meets_threshold(v.n, v.q, v.d);
                expected_verdicts.push_back(v);
            end
        end
        outstanding = expected_verdicts.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the cyclic code minimum distance check
// Drives directed corner requests and then randomised ones in bursts, with a
// receiver that stalls in changing patterns. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int MODULUS_BITS = 17;
    localparam int COORDINATES  = 5;
    localparam int IN_W         = ((3*MODULUS_BITS+7)/8)*8;
    localparam logic [MODULUS_BITS-1:0] N_MAX = '1;
    localparam int RANDOM_REQS  = 100;

    typedef enum {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE,
        RX_HOLD
    } rx_mode_t;

    logic            aclk     = 1'b0;
    logic            aresetn  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata  = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [7:0]      m_tdata;

    int mismatches;
    int outstanding;
    int burst_left = 1;

    cyclic_code_min_distance_check #(
        .MODULUS_BITS (MODULUS_BITS),
        .COORDINATES  (COORDINATES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ccmd_checker #(
        .MODULUS_BITS (MODULUS_BITS),
        .COORDINATES  (COORDINATES),
        .IN_W         (IN_W)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hold the request until taken; keep tvalid up inside a burst.
    task automatic send_request(input logic [MODULUS_BITS-1:0] n,
                                input logic [MODULUS_BITS-1:0] q,
                                input logic [MODULUS_BITS-1:0] d);
        int gap;
        s_tdata  <= {{(IN_W-3*MODULUS_BITS){1'b0}}, d, q, n};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(8, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(24, 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    // Drop tvalid and hold off until every result is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic random_request();
        int unsigned              kind;
        logic [MODULUS_BITS-1:0]  n;
        logic [MODULUS_BITS-1:0]  q;
        logic [MODULUS_BITS-1:0]  d;
        kind = $urandom_range(99, 0);
        q    = MODULUS_BITS'($urandom_range(N_MAX, 0));
        if (kind < 4) begin
            n = MODULUS_BITS'($urandom_range(1, 0));
        end else if (kind < 70) begin
            n = MODULUS_BITS'($urandom_range(255, 2));
        end else if (kind < 88) begin
            n = MODULUS_BITS'($urandom_range(4095, 256));
        end else begin
            n = MODULUS_BITS'($urandom_range(N_MAX, 65536));
        end
        // Large moduli only get thresholds above n/2 so they fail at once.
        if (n < 2 || n >= 65536) begin
            d = MODULUS_BITS'($urandom_range(N_MAX, (n >> 1) + 1));
        end else begin
            d = MODULUS_BITS'($urandom_range((n >> 1) + 2, 0));
        end
        if (n > 1 && $urandom_range(3, 0) == 0) begin
            q = MODULUS_BITS'($urandom_range(3, 0));
        end
        send_request(n, q, d);
    endtask

    initial begin : receiver
        rx_mode_t mode;
        int       span;
        forever begin
            mode = rx_mode_t'($urandom_range(3, 0));
            span = $urandom_range(200, 1);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= 1'($urandom_range(1, 0));
                    RX_SPARSE: m_tready <= ($urandom_range(9, 0) == 0);
                    default:   m_tready <= 1'b0;
                endcase
            end
        end
    end

    initial begin : stimulus
        int i;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // modulus one and modulus zero: no offsets at all
        send_request(17'd1, 17'd0, 17'd0);
        send_request(17'd1, N_MAX, N_MAX);
        send_request(17'd0, 17'd5, N_MAX);
        send_request(17'd2, 17'd1, 17'd1);
        send_request(17'd2, 17'd0, 17'd1);
        send_request(17'd3, 17'd2, 17'd1);
        send_request(17'd3, 17'd2, 17'd2);
        // zero threshold
        send_request(17'd7, 17'd2, 17'd0);
        send_request(17'd13, 17'd5, 17'd4);
        send_request(17'd13, 17'd5, 17'd6);
        send_request(17'd31, 17'd2, 17'd10);
        send_request(17'd1000, 17'd999, 17'd1);
        send_request(17'd4096, 17'd1, 17'd2048);
        send_request(17'd4096, 17'd1, 17'd1);
        // largest modulus: full walk, then an early exit at the first offset
        send_request(N_MAX, N_MAX - 1'b1, 17'd0);
        send_request(N_MAX, 17'd0, N_MAX);
        send_request(N_MAX, N_MAX, 17'd1);
        send_request(17'd131070, 17'd3, 17'd65535);
        send_request(17'd100000, N_MAX, 17'd30000);
        send_request(17'd65536, 17'd65535, 17'd32768);
        drain_results();

        for (i = 0; i < RANDOM_REQS; i++) begin
            if (i == RANDOM_REQS / 2) begin
                drain_results();
            end
            random_request();
        end

        drain_results();
        repeat (50) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #32_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
